/* hw/rtl/ep_pkg.sv */
// Shared types and constants for the entangling prefetcher.
// No dependencies.
package ep_pkg;
  localparam int HistDepth = 1024;
  localparam int HistAw = $clog2(HistDepth);
  localparam int PairDepth = 4096;
  localparam int PairAw = $clog2(PairDepth);
  localparam int Degree = 2;
  localparam int DegW = $clog2(Degree + 1);
  localparam int LineW = 58;
  localparam int AddrW = 48;
  localparam int QDepth = 2;
  localparam int QAw = $clog2(QDepth);
  localparam logic [15:0] LatencyReset = 16'd171;
  localparam logic [0:0] RegMissLatency = 1'b0;
  localparam logic [0:0] RegPredictEnable = 1'b1;
  localparam logic SrcPair = 1'b0;
  localparam logic SrcNext = 1'b1;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic [AddrW-1:0] instr;
    logic [AddrW-1:0] now;
  } acc_t;

  // Training result handed from the search front to the table back.
  typedef struct packed {
    logic [LineW-1:0] line;
    logic             wr;
    logic [LineW-1:0] timely;
    logic [LineW-1:0] recent;
  } job_t;
endpackage

/* hw/rtl/ep_if.sv */
// Valid/ready channel interface.
// Depends on nothing; payload width by parameter.
interface ep_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ep_front.sv */
// Front: history buffer, newest-to-oldest search, append.
// Depends on ep_pkg.
module ep_front import ep_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  acc_t             in_acc,
  input  logic [15:0]      miss_latency,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_LAST = 2'd2, S_DONE = 2'd3;

  logic [LineW-1:0] mem_line [HistDepth];
  logic [AddrW-1:0] mem_instr [HistDepth];
  logic [AddrW-1:0] mem_time [HistDepth];
  // entries below the fill count have been written; the head wraps only once it is full
  logic [HistAw:0] fill_r;

  logic [1:0] state_r, state_nxt;
  logic [HistAw-1:0] head_r, pos_r;
  logic [HistAw:0] cnt_r;
  acc_t acc_r;
  logic rd_ok_r;
  logic [LineW-1:0] rd_line_r;
  logic [AddrW-1:0] rd_instr_r, rd_time_r;
  logic have_t_r, have_r_r;
  logic [LineW-1:0] tim_r, rec_r;
  logic [AddrW-1:0] age;
  logic hit;

  assign in_ready = (state_r == S_IDLE);
  assign job_valid = (state_r == S_DONE);
  assign job.line = acc_r.line;
  assign job.wr = have_t_r && (tim_r != acc_r.line);
  assign job.timely = tim_r;
  assign job.recent = rec_r;

  assign age = acc_r.now - rd_time_r;
  assign hit = rd_ok_r && (rd_line_r != '0) && (rd_instr_r == acc_r.instr);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: if (cnt_r == (HistAw+1)'(HistDepth - 1)) state_nxt = S_LAST;
      S_LAST: state_nxt = S_DONE;
      S_DONE: if (job_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Registered read: one history entry per cycle, compared in the cycle after it is read.
  always_ff @(posedge clk) begin
    rd_line_r <= mem_line[pos_r];
    rd_instr_r <= mem_instr[pos_r];
    rd_time_r <= mem_time[pos_r];
    if (state_r == S_DONE && job_ready) begin
      mem_line[head_r] <= acc_r.line;
      mem_instr[head_r] <= acc_r.instr;
      mem_time[head_r] <= acc_r.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      fill_r <= '0;
      rd_ok_r <= 1'b0;
      pos_r <= '0;
      cnt_r <= '0;
      have_t_r <= 1'b0;
      have_r_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_valid) begin
        acc_r <= in_acc;
        pos_r <= head_r - 1'b1;
        cnt_r <= '0;
        have_t_r <= 1'b0;
        have_r_r <= 1'b0;
        rd_ok_r <= 1'b0;
      end else if (state_r == S_SCAN || state_r == S_LAST) begin
        rd_ok_r <= (state_r == S_SCAN) && ({1'b0, pos_r} < fill_r);
        pos_r <= pos_r - 1'b1;
        cnt_r <= cnt_r + 1'b1;
        if (hit && !have_r_r) begin
          have_r_r <= 1'b1;
          rec_r <= rd_line_r;
        end
        if (hit && !have_t_r && age >= AddrW'(miss_latency)) begin
          have_t_r <= 1'b1;
          tim_r <= rd_line_r;
        end
      end else if (state_r == S_DONE && job_ready) begin
        if (fill_r != (HistAw+1)'(HistDepth)) fill_r <= fill_r + 1'b1;
        head_r <= head_r + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && job_ready |=> head_r == $past(head_r) + 1'b1)
    else $error("head must advance after append");
  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.wr |-> have_r_r)
    else $error("timely source without recent source");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !in_ready)
    else $error("accept during scan");
endmodule

/* hw/rtl/ep_back.sv */
// Back: pair tables, training writes, prediction chain and next-line fill.
// Depends on ep_pkg.
module ep_back import ep_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  input  logic             predict_enable,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LineW-1:0] out_pf_line,
  output logic             out_prefetch_source,
  output logic             out_last_of_access
);
  localparam logic [2:0] B_IDLE = 3'd0, B_WR = 3'd1, B_RD = 3'd2, B_CHK = 3'd3,
                         B_EMIT = 3'd4, B_FILL = 3'd5, B_CLR = 3'd6;

  logic [LineW-1:0] tk [PairDepth];
  logic [LineW-1:0] tt [PairDepth];
  logic [LineW-1:0] rk [PairDepth];
  logic [LineW-1:0] rt [PairDepth];
  logic tv_m [PairDepth];
  logic rv_m [PairDepth];

  logic [2:0] st_r;
  job_t j_r;
  logic [LineW-1:0] cur_r, k_r, t_r;
  logic v_r, first_r;
  logic [DegW-1:0] cnt_r;
  logic [LineW-1:0] step_r;
  logic [PairAw-1:0] idx;
  logic [PairAw-1:0] clr_r;

  assign idx = cur_r[PairAw-1:0];
  assign job_ready = (st_r == B_IDLE);

  // valid bits live in RAM; a sweep after reset clears them
  always_ff @(posedge clk) begin
    if (st_r == B_CLR) begin
      tv_m[clr_r] <= 1'b0;
      rv_m[clr_r] <= 1'b0;
    end else if (st_r == B_WR && j_r.wr) begin
      tk[j_r.timely[PairAw-1:0]] <= j_r.timely;
      tt[j_r.timely[PairAw-1:0]] <= j_r.line;
      tv_m[j_r.timely[PairAw-1:0]] <= 1'b1;
      rk[j_r.recent[PairAw-1:0]] <= j_r.recent;
      rt[j_r.recent[PairAw-1:0]] <= j_r.line;
      rv_m[j_r.recent[PairAw-1:0]] <= 1'b1;
    end
    if (first_r) begin
      k_r <= tk[idx];
      t_r <= tt[idx];
      v_r <= tv_m[idx];
    end else begin
      k_r <= rk[idx];
      t_r <= rt[idx];
      v_r <= rv_m[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR;
      clr_r <= '0;
      out_valid <= 1'b0;
      cnt_r <= '0;
      first_r <= 1'b1;
    end else begin
      case (st_r)
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == PairAw'(PairDepth - 1)) st_r <= B_IDLE;
        end
        B_IDLE: if (job_valid) begin
          j_r <= job;
          st_r <= B_WR;
        end
        B_WR: begin
          cur_r <= j_r.line;
          first_r <= 1'b1;
          cnt_r <= '0;
          step_r <= LineW'(1);
          st_r <= predict_enable ? B_RD : B_FILL;
        end
        B_RD: begin
          st_r <= B_CHK;
        end
        B_CHK: begin
          if (v_r && k_r == cur_r) begin
            out_valid <= 1'b1;
            out_pf_line <= t_r;
            out_prefetch_source <= SrcPair;
            out_last_of_access <= (cnt_r == DegW'(Degree - 1));
            cur_r <= t_r;
            cnt_r <= cnt_r + 1'b1;
            st_r <= B_EMIT;
          end else if (first_r) begin
            st_r <= B_RD;
          end else begin
            st_r <= B_FILL;
          end
          first_r <= 1'b0;
        end
        B_EMIT: if (out_ready) begin
          out_valid <= 1'b0;
          st_r <= (cnt_r == DegW'(Degree)) ? B_IDLE : B_RD;
        end
        B_FILL: begin
          if (!out_valid || out_ready) begin
            if (cnt_r == DegW'(Degree)) begin
              out_valid <= 1'b0;
              st_r <= B_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_pf_line <= j_r.line + step_r;
              out_prefetch_source <= SrcNext;
              out_last_of_access <= (cnt_r == DegW'(Degree - 1));
              step_r <= step_r + 1'b1;
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_access |-> cnt_r == DegW'(Degree))
    else $error("last flag off count");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pf_line))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_IDLE |-> !out_valid)
    else $error("result left behind");
endmodule

/* hw/rtl/entangling_prefetcher.sv */
// Top level of the entangling prefetcher: config registers, front, queue, back.
// Depends on ep_pkg, ep_if, ep_front, ep_back.
//   channel | dir | payload
//   in_     | in  | line_address, instr_address, access_cycle
//   out_    | out | pf_line, prefetch_source, last_of_access
//   cfg_    | in  | we, index, 16-bit data
// The front takes a new access only when idle: it scans the whole single-port history,
// does the last compare, hands off the job and then returns to idle.
// The back works on one job at a time, from training write to prediction and fill; a two-job queue lets
// it overlap the next scan. A stalled output holds the back, then the queue, then the front.
// Reset is synchronous, active low; after it the back clears the valid bits of all PairDepth
// table entries before it takes its first job.
module entangling_prefetcher import ep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ep_if.sink          in_ch,
  ep_if.source        out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] lat_r;
  logic pe_r;
  acc_t acc;
  job_t fj, bj;
  logic fv, fr;
  job_t q_r [QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0] n_r;
  logic bv, br;
  logic [LineW-1:0] pl;
  logic ps, pla;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= LatencyReset;
      pe_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == RegMissLatency) lat_r <= cfg_data;
      if (cfg_index == RegPredictEnable) pe_r <= cfg_data[0];
    end
  end

  assign acc = in_ch.data;

  ep_front u_front (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_acc(acc), .miss_latency(lat_r), .job_valid(fv), .job_ready(fr), .job(fj));

  assign fr = (n_r != (QAw+1)'(QDepth));
  assign bv = (n_r != '0);
  assign bj = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (fv && fr) q_r[wp_r] <= fj;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r <= '0;
    end else begin
      if (fv && fr) wp_r <= wp_r + 1'b1;
      if (bv && br) rp_r <= rp_r + 1'b1;
      n_r <= n_r + (QAw+1)'(fv && fr) - (QAw+1)'(bv && br);
    end
  end

  ep_back u_back (.clk, .rst_n, .job_valid(bv), .job_ready(br), .job(bj),
    .predict_enable(pe_r), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_pf_line(pl), .out_prefetch_source(ps), .out_last_of_access(pla));

  assign out_ch.data = {pl, ps, pla};

  assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= (QAw+1)'(QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    n_r == '0 |-> !bv)
    else $error("job offered from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    n_r == (QAw+1)'(QDepth) |-> !fr)
    else $error("job taken into full queue");
endmodule

/* sim/entangling_prefetcher_test.sv */
// Testbench for the entangling prefetcher: random and directed accesses, a
// scoreboard that tracks history and pair tables, and a stall pattern on the output.
// Depends on ep_pkg, ep_if and entangling_prefetcher.
module entangling_prefetcher_test;
  import ep_pkg::*;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic             src;
    logic             last;
  } pf_t;

  class prefetch_scoreboard;
    logic [LineW-1:0] hist_line[HistDepth];
    logic [AddrW-1:0] hist_instr[HistDepth];
    logic [AddrW-1:0] hist_stamp[HistDepth];
    logic [HistAw-1:0] hist_head;
    logic [LineW-1:0] tpair_key[PairDepth], tpair_tgt[PairDepth];
    logic [LineW-1:0] rpair_key[PairDepth], rpair_tgt[PairDepth];
    bit               tpair_ok[PairDepth], rpair_ok[PairDepth];
    logic [15:0]      latency;
    bit               enable;
    pf_t              pending_pf[$];
    int               mismatches;

    function new();
      hist_line = '{default: '0};
      hist_instr = '{default: '0};
      hist_stamp = '{default: '0};
      tpair_ok = '{default: 1'b0};
      rpair_ok = '{default: 1'b0};
      hist_head = '0;
      latency = LatencyReset;
      enable = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == RegMissLatency) latency = val;
      else enable = val[0];
    endfunction

    function void note_access(acc_t a);
      logic [LineW-1:0] timely, recent, cur;
      logic [AddrW-1:0] age;
      logic [HistAw-1:0] pos;
      logic [PairAw-1:0] idx;
      bit have_t, have_r, chained;
      int unsigned k;
      have_t = 0; have_r = 0; timely = '0; recent = '0;
      pos = hist_head;
      for (int n = 0; n < HistDepth; n++) begin
        pos = pos - 1'b1;
        if (hist_line[pos] != 0 && hist_instr[pos] == a.instr) begin
          if (!have_r) begin
            have_r = 1; recent = hist_line[pos];
          end
          age = a.now - hist_stamp[pos];
          if (!have_t && age >= {32'd0, latency}) begin
            have_t = 1; timely = hist_line[pos];
          end
        end
      end
      if (have_t && timely != a.line) begin
        idx = timely[PairAw-1:0];
        tpair_key[idx] = timely; tpair_tgt[idx] = a.line; tpair_ok[idx] = 1;
        idx = recent[PairAw-1:0];
        rpair_key[idx] = recent; rpair_tgt[idx] = a.line; rpair_ok[idx] = 1;
      end
      hist_line[hist_head] = a.line;
      hist_instr[hist_head] = a.instr;
      hist_stamp[hist_head] = a.now;
      hist_head = hist_head + 1'b1;

      k = 0;
      cur = a.line;
      if (enable) begin
        idx = cur[PairAw-1:0];
        if (tpair_ok[idx] && tpair_key[idx] == cur) begin
          cur = tpair_tgt[idx];
          pending_pf.push_back('{cur, SrcPair, k == Degree - 1});
          k++;
        end
        chained = 1;
        while (k < Degree && chained) begin
          idx = cur[PairAw-1:0];
          chained = rpair_ok[idx] && rpair_key[idx] == cur;
          if (chained) begin
            cur = rpair_tgt[idx];
            pending_pf.push_back('{cur, SrcPair, k == Degree - 1});
            k++;
          end
        end
      end
      for (int s = 1; k < Degree; s++) begin
        pending_pf.push_back('{a.line + LineW'(s), SrcNext, k == Degree - 1});
        k++;
      end
    endfunction

    function void check_prefetch(pf_t got);
      pf_t want;
      if (pending_pf.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected prefetch %h", got);
        return;
      end
      want = pending_pf.pop_front();
      if (got.line !== want.line || got.src !== want.src || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("prefetch mismatch: line %h/%h src %b/%b last %b/%b (exp/got)",
                   want.line, got.line, want.src, got.src, want.last, got.last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;

  ep_if #(.W($bits(acc_t))) in_ch ();
  ep_if #(.W($bits(pf_t)))  out_ch ();

  entangling_prefetcher dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prefetch_scoreboard sb = new();
  int idle_cycles;
  logic [AddrW-1:0] core_cycle;
  logic [LineW-1:0] line_pool[8];
  logic [AddrW-1:0] instr_pool[3];
  logic [2:0] loop_pos;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) sb.note_access(acc_t'(in_ch.data));
      if (out_ch.valid && out_ch.ready) sb.check_prefetch(pf_t'(out_ch.data));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 30000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver stall pattern: free-running, light stalls, then long stalls
  int stall_mode_cnt, stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode_cnt <= 0;
      stall_left <= 0;
    end else begin
      stall_mode_cnt <= (stall_mode_cnt + 1) % 3000;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_mode_cnt < 1000) begin
        out_ch.ready <= 1'b1;
      end else if (stall_mode_cnt < 2000) begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(5, 30);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold valid across a burst; drop it only when a gap follows
  task automatic send_access(acc_t a, int gap);
    in_ch.valid <= 1'b1;
    in_ch.data <= a;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_pf.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic acc_t next_access();
    acc_t a;
    int r;
    r = $urandom_range(0, 99);
    core_cycle = core_cycle + AddrW'($urandom_range(0, 250));
    if (r < 80) begin
      // looping access stream so pairs form and get followed
      a.line = line_pool[loop_pos];
      a.instr = instr_pool[2'(loop_pos % 3)];
      loop_pos = loop_pos + 1'b1;
      if ($urandom_range(0, 9) == 0) loop_pos = 3'($urandom_range(0, 7));
    end else if (r < 90) begin
      a.line = LineW'({$urandom, $urandom});
      a.instr = instr_pool[2'($urandom_range(0, 2))];
    end else begin
      a.line = LineW'({$urandom, $urandom});
      a.instr = AddrW'({$urandom, $urandom});
      if (r == 95) core_cycle = AddrW'({$urandom, $urandom});
    end
    if (r == 97) a.line = '0;
    if (r == 98) a.line = '1;
    a.now = core_cycle;
    return a;
  endfunction

  task automatic new_pools();
    for (int i = 0; i < 8; i++) line_pool[3'(i)] = LineW'({$urandom, $urandom});
    // two lines sharing a pair-table index to force conflicts
    line_pool[7] = {line_pool[3][LineW-1:PairAw] + 1'b1, line_pool[3][PairAw-1:0]};
    for (int i = 0; i < 3; i++) instr_pool[2'(i)] = AddrW'({$urandom, $urandom});
    loop_pos = '0;
  endtask

  task automatic random_phase(int count);
    int burst;
    burst = 0;
    new_pools();
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      send_access(next_access(), burst == 0 ? $urandom_range(1, 40) : 0);
    end
    drain();
  endtask

  logic [15:0] lat_set[6] = '{16'd0, 16'd65535, 16'd171, 16'd50, 16'd300, 16'd1};
  bit en_set[6] = '{1, 1, 1, 0, 1, 1};

  initial begin
    acc_t a;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    core_cycle = 1000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // warm-up at reset settings, then directed cases with prediction on
    random_phase(20);
    write_reg(RegMissLatency, 16'd10);
    write_reg(RegPredictEnable, 16'd1);
    a = '{line: 58'h5, instr: 48'h10, now: 48'd100};        send_access(a, 0);
    a = '{line: 58'h9, instr: 48'h10, now: 48'd200};        send_access(a, 0);
    a = '{line: 58'h5, instr: 48'h10, now: 48'd300};        send_access(a, 0);
    a = '{line: 58'h9, instr: 48'h10, now: 48'd305};        send_access(a, 0);
    a = '{line: 58'h5, instr: 48'h10, now: 48'd400};        send_access(a, 3);
    a = '{line: '1, instr: '1, now: '1};                    send_access(a, 0);
    a = '{line: 58'h0, instr: '1, now: 48'd5};              send_access(a, 0);
    a = '{line: 58'h7, instr: '1, now: 48'd6};              send_access(a, 0);
    a = '{line: '1, instr: '1, now: 48'd7};                 send_access(a, 0);
    a = '{line: 58'h1005, instr: 48'h10, now: 48'd500};     send_access(a, 0);
    a = '{line: 58'h5, instr: 48'h10, now: 48'd600};        send_access(a, 0);
    a = '{line: 58'h5, instr: 48'h10, now: 48'd700};        send_access(a, 0);
    a = '{line: 58'h2aaa, instr: 48'h0, now: 48'd0};        send_access(a, 0);
    a = '{line: 58'h3555, instr: 48'h0, now: 48'd900};      send_access(a, 0);
    a = '{line: 58'h2aaa, instr: 48'h0, now: 48'd2000};     send_access(a, 0);
    a = '{line: 58'h3555, instr: 48'h0, now: 48'd2100};     send_access(a, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(RegMissLatency, lat_set[p]);
      write_reg(RegPredictEnable, {15'd0, en_set[p]});
      random_phase(p == 5 ? 30 : 100);
    end

    if (sb.mismatches == 0 && sb.pending_pf.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* entangling_prefetcher.f */
hw/rtl/ep_pkg.sv
hw/rtl/ep_if.sv
hw/rtl/ep_front.sv
hw/rtl/ep_back.sv
hw/rtl/entangling_prefetcher.sv
sim/entangling_prefetcher_test.sv
